// ===== src/wbps_pkg.sv =====
// Package for the wildcard byte pattern scan unit: payload and config types,
// register indexes and size constants. Depends on nothing.
package wbps_pkg;

  localparam int unsigned MaxPatternDef = 32;
  localparam int unsigned OffsetBitsDef = 32;
  localparam int unsigned PatBytes      = 32;
  localparam int unsigned LenW          = 6;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatLow    = 3'd0,
    RegPatSecond = 3'd1,
    RegPatThird  = 3'd2,
    RegPatHigh   = 3'd3,
    RegWildMask  = 3'd4,
    RegPatLen    = 3'd5
  } wbps_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wbps_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } wbps_out_t;

  typedef struct packed {
    logic [PatBytes-1:0][7:0] pat_bytes;
    logic [PatBytes-1:0]      wild_mask;
    logic [LenW-1:0]          eff_len;
  } wbps_cfg_t;

endpackage

// ===== src/wbps_match.sv =====
// Masked compare of the byte window against the configured pattern.
// Depends on wbps_pkg.
module wbps_match #(
  parameter int unsigned MaxPattern = wbps_pkg::MaxPatternDef
) (
  input  wbps_pkg::wbps_cfg_t             cfg_i,
  input  logic [MaxPattern-1:0][7:0]      win_i,
  output logic                            match_o
);
  import wbps_pkg::*;

  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  logic [LenW-1:0] pos;
  logic [7:0]      got;

  // pattern byte j lines up with the byte received len-1-j items ago
  always_comb begin
    match_o = 1'b1;
    pos     = '0;
    got     = '0;
    for (int j = 0; j < MaxPattern; j++) begin
      pos = cfg_i.eff_len - LenW'(1) - LenW'(j);
      got = win_i[pos[IdxW-1:0]];
      if ((LenW'(j) < cfg_i.eff_len) && !cfg_i.wild_mask[j] &&
          (got != cfg_i.pat_bytes[j])) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

// ===== src/wildcard_byte_pattern_scan_unit.sv =====
// Top level of the wildcard byte pattern scan unit: config registers, byte
// window, byte counter and result register. Depends on wbps_pkg, wbps_match.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | wbps_in_t  data_byte, last_byte
//  out     | output    | out_valid_o/out_ready_i | wbps_out_t found, match_offset
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle while in_ready_o is high; a result is in the output register
// the cycle after its byte. The window shift and masked compare sit in one stage.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset clears the window, counter, flags and config to their reset values.
module wildcard_byte_pattern_scan_unit #(
  parameter int unsigned MaxPattern = wbps_pkg::MaxPatternDef,
  parameter int unsigned OffsetBits = wbps_pkg::OffsetBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wbps_pkg::wbps_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wbps_pkg::wbps_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wbps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wbps_pkg::*;

  logic [3:0][63:0]            pat_q;
  logic [PatBytes-1:0]         wild_q;
  logic [LenW-1:0]             len_q;
  logic [MaxPattern-1:0][7:0]  win_q, win_d;
  logic [OffsetBits-1:0]       seen_q, seen_d, seen_inc;
  logic                        rep_q, rep_d;
  logic                        out_valid_q, out_valid_d;
  wbps_out_t                   out_q, out_d;
  wbps_cfg_t                   cfg;
  logic                        in_acc, counted, hit, win_match;
  logic [OffsetBits-1:0]       offs;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cfg.pat_bytes = pat_q;
    cfg.wild_mask = wild_q;
    if (len_q == '0) begin
      cfg.eff_len = LenW'(1);
    end else if (len_q > LenW'(MaxPattern)) begin
      cfg.eff_len = LenW'(MaxPattern);
    end else begin
      cfg.eff_len = len_q;
    end
  end

  always_comb begin
    win_d[0] = in_data_i.data_byte;
    for (int k = 1; k < MaxPattern; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  wbps_match #(
    .MaxPattern(MaxPattern)
  ) u_match (
    .cfg_i  (cfg),
    .win_i  (win_d),
    .match_o(win_match)
  );

  assign counted  = ~&seen_q;
  assign seen_inc = seen_q + OffsetBits'(1);
  assign offs     = seen_inc - OffsetBits'(cfg.eff_len);
  assign hit      = !rep_q && counted && (seen_inc >= OffsetBits'(cfg.eff_len)) && win_match;

  always_comb begin
    seen_d      = seen_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (in_acc) begin
      if (counted) begin
        seen_d = seen_inc;
      end
      if (hit) begin
        rep_d              = 1'b1;
        out_valid_d        = 1'b1;
        out_d.found        = 1'b1;
        out_d.match_offset = 32'(offs);
      end else if (in_data_i.last_byte && !rep_q) begin
        out_valid_d        = 1'b1;
        out_d.found        = 1'b0;
        out_d.match_offset = '0;
      end
      if (in_data_i.last_byte) begin
        seen_d = '0;
        rep_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      wild_q <= '0;
      len_q  <= LenW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPatLow:    pat_q[0] <= cfg_data_i;
        RegPatSecond: pat_q[1] <= cfg_data_i;
        RegPatThird:  pat_q[2] <= cfg_data_i;
        RegPatHigh:   pat_q[3] <= cfg_data_i;
        RegWildMask:  wild_q   <= cfg_data_i[PatBytes-1:0];
        RegPatLen:    len_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      seen_q      <= '0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        win_q <= win_d;
      end
      seen_q      <= seen_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
